/* rtl/aarm_pkg.sv */
// ----------------------------------------------------------------------------
// aarm_pkg
// Types, widths, CORDIC constants and rounding helpers for the axis-angle
// rotation matrix pipeline.
// ----------------------------------------------------------------------------
package aarm_pkg;

	localparam int CW        = 16;          // component width, Q2.14
	localparam int FRAC      = CW - 2;      // fraction bits of a component
	localparam int ANG_W     = 16;          // binary angle width
	localparam int XW        = 34;          // CORDIC datapath width, Q2.30 plus guard
	localparam int CS_SH     = 30 - FRAC;   // Q2.30 to Q2.14 shift
	localparam int OW        = CW + 2;      // width of 1-c and of t_i
	localparam int SAW       = CW + 1;      // width of s*a_k terms
	localparam int PW        = CW + 3;      // width of t_i*a_j terms
	localparam int SUMW      = CW + 4;      // width of an entry before saturation
	localparam int RW        = 40;          // width of the rounding helper
	localparam int CORDIC_STEPS_DEF = 16;
	localparam int GAIN_Q30  = 652032874;

	localparam logic [31:0] ATAN_TAB [32] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
		32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
		32'h00000001, 32'h00000000
	};

	typedef struct packed {
		logic signed [CW-1:0] axis_x;
		logic signed [CW-1:0] axis_y;
		logic signed [CW-1:0] axis_z;
		logic [ANG_W-1:0]     turn_angle;
	} axis_item_t;

	typedef struct packed {
		logic signed [CW-1:0] row0_col0;
		logic signed [CW-1:0] row0_col1;
		logic signed [CW-1:0] row0_col2;
		logic signed [CW-1:0] row1_col0;
		logic signed [CW-1:0] row1_col1;
		logic signed [CW-1:0] row1_col2;
		logic signed [CW-1:0] row2_col0;
		logic signed [CW-1:0] row2_col1;
		logic signed [CW-1:0] row2_col2;
	} rot_mat_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
	} vec_t;

	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [XW-1:0] z;
		logic                 flip;
		vec_t                 ax;
	} cordic_st_t;

	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic                 flip;
		vec_t                 ax;
	} cs_res_t;

	// Divide by 2^sh, rounding half away from zero.
	function automatic logic signed [RW-1:0] rnd_shr(input logic signed [RW-1:0] p,
		input int sh);
		logic [RW-1:0] mag;
		logic [RW-1:0] q;
		mag = p[RW-1] ? RW'(-p) : RW'(p);
		q = (mag + (RW'(1) << (sh - 1))) >> sh;
		return p[RW-1] ? -signed'(q) : signed'(q);
	endfunction

	function automatic logic signed [CW-1:0] sat_cw(input logic signed [SUMW-1:0] v);
		logic signed [SUMW-1:0] hi;
		logic signed [SUMW-1:0] lo;
		hi = SUMW'((1 << (CW - 1)) - 1);
		lo = -hi - SUMW'(1);
		if (v > hi) begin
			return CW'(hi);
		end else if (v < lo) begin
			return CW'(lo);
		end
		return CW'(v);
	endfunction

endpackage

/* rtl/aarm_cordic.sv */
// ----------------------------------------------------------------------------
// aarm_cordic
// Angle reduction followed by one register stage per CORDIC iteration.
// Produces unscaled cosine and sine in Q2.30 with the half-turn flag.
// ----------------------------------------------------------------------------
module aarm_cordic import aarm_pkg::*; #(
	parameter int STEPS = CORDIC_STEPS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  axis_item_t in_item,
	output logic       out_valid,
	input  logic       out_ready,
	output cs_res_t    out_cs
);

	cordic_st_t       st_s  [STEPS+1];
	logic [STEPS:0]   vld_s;
	logic [STEPS+1:0] ld;
	cordic_st_t       st0;

	// A stage loads when it is empty or its successor loads.
	assign ld[STEPS+1] = out_ready;
	for (genvar k = 0; k <= STEPS; k++) begin : g_ld
		assign ld[k] = !vld_s[k] || ld[k+1];
	end
	assign in_ready = ld[0];

	// Fold the angle into [-quarter, +quarter) turn; the flip negates c and s later.
	always_comb begin
		logic flip;
		logic [ANG_W-1:0] r;
		flip = in_item.turn_angle[ANG_W-1] ^ in_item.turn_angle[ANG_W-2];
		r = in_item.turn_angle;
		if (flip) begin
			r[ANG_W-1] = ~in_item.turn_angle[ANG_W-1];
		end
		st0.x    = XW'(GAIN_Q30);
		st0.y    = '0;
		st0.z    = signed'({{(XW-ANG_W-16){r[ANG_W-1]}}, r, 16'b0});
		st0.flip = flip;
		st0.ax.x = in_item.axis_x;
		st0.ax.y = in_item.axis_y;
		st0.ax.z = in_item.axis_z;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (ld[0]) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ld[0] && in_valid) begin
			st_s[0] <= st0;
		end
	end

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		cordic_st_t nxt;

		always_comb begin
			logic signed [XW-1:0] xs;
			logic signed [XW-1:0] ys;
			logic signed [XW-1:0] zs;
			logic signed [XW-1:0] at;
			xs = st_s[k].x;
			ys = st_s[k].y;
			zs = st_s[k].z;
			at = signed'({{(XW-32){1'b0}}, ATAN_TAB[k]});
			nxt = st_s[k];
			// Rotate toward z, counterclockwise when z is non-negative.
			if (!zs[XW-1]) begin
				nxt.x = xs - (ys >>> k);
				nxt.y = ys + (xs >>> k);
				nxt.z = zs - at;
			end else begin
				nxt.x = xs + (ys >>> k);
				nxt.y = ys - (xs >>> k);
				nxt.z = zs + at;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (ld[k+1]) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (ld[k+1] && vld_s[k]) begin
				st_s[k+1] <= nxt;
			end
		end
	end

	assign out_valid   = vld_s[STEPS];
	assign out_cs.x    = st_s[STEPS].x;
	assign out_cs.y    = st_s[STEPS].y;
	assign out_cs.flip = st_s[STEPS].flip;
	assign out_cs.ax   = st_s[STEPS].ax;

endmodule

/* rtl/axis_angle_rotation_matrix.sv */
// ----------------------------------------------------------------------------
// axis_angle_rotation_matrix
// Rodrigues 3x3 rotation matrix from a Q2.14 axis and a binary angle.
// ----------------------------------------------------------------------------
// The block takes one axis and angle item in every cycle unless mat_ready
// backpressure has filled the pipeline, and returns one matrix item for each,
// in order. An item passes CORDIC_STEPS + 5 registers: one of angle folding,
// one per CORDIC iteration, then rounding of c and s, the (1-c)*a and s*a
// products, the nine t*a products, and the summing and saturating output
// register. The axis is used as given (no normalization); entries are
// Q2.14 and saturate at the ends of the 16-bit range. Backpressure on
// mat_ready stalls only the stages that are full, so empty stages keep
// taking items.
module axis_angle_rotation_matrix import aarm_pkg::*; #(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       axis_valid,
	output logic       axis_ready,
	input  axis_item_t axis_item,
	output logic       mat_valid,
	input  logic       mat_ready,
	output rot_mat_t   mat_item
);

	logic    cs_valid;
	logic    cs_ready;
	cs_res_t cs;

	aarm_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (axis_valid),
		.in_ready  (axis_ready),
		.in_item   (axis_item),
		.out_valid (cs_valid),
		.out_ready (cs_ready),
		.out_cs    (cs)
	);

	logic v_s1, v_s2, v_s3, v_s4;
	logic ld1, ld2, ld3, ld4;

	assign ld4      = !v_s4 || mat_ready;
	assign ld3      = !v_s3 || ld4;
	assign ld2      = !v_s2 || ld3;
	assign ld1      = !v_s1 || ld2;
	assign cs_ready = ld1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (ld1) v_s1 <= cs_valid;
			if (ld2) v_s2 <= v_s1;
			if (ld3) v_s3 <= v_s2;
			if (ld4) v_s4 <= v_s3;
		end
	end

	// Stage 1: round c and s to Q2.14, undo the half-turn fold, clamp to [-1, 1].
	logic signed [CW-1:0] c_s1, s_s1;
	logic signed [OW-1:0] omc_s1;
	vec_t                 ax_s1;
	logic signed [CW-1:0] c_n, s_n;

	always_comb begin
		logic signed [SUMW-1:0] cr;
		logic signed [SUMW-1:0] sr;
		logic signed [SUMW-1:0] one;
		one = SUMW'(1 << FRAC);
		cr = SUMW'(rnd_shr(RW'(cs.x), CS_SH));
		sr = SUMW'(rnd_shr(RW'(cs.y), CS_SH));
		if (cs.flip) begin
			cr = -cr;
			sr = -sr;
		end
		if (cr > one) cr = one;
		if (cr < -one) cr = -one;
		if (sr > one) sr = one;
		if (sr < -one) sr = -one;
		c_n = CW'(cr);
		s_n = CW'(sr);
	end

	always_ff @(posedge clk) begin
		if (ld1 && cs_valid) begin
			c_s1   <= c_n;
			s_s1   <= s_n;
			omc_s1 <= OW'(1 << FRAC) - OW'(c_n);
			ax_s1  <= cs.ax;
		end
	end

	// Stage 2: t_k = (1-c)*a_k and the s*a_k terms.
	logic signed [CW-1:0]  a1 [3];
	logic signed [OW-1:0]  t_n [3];
	logic signed [SAW-1:0] sa_n [3];
	logic signed [OW-1:0]  t_s2 [3];
	logic signed [SAW-1:0] sa_s2 [3];
	logic signed [CW-1:0]  a_s2 [3];
	logic signed [CW-1:0]  c_s2;

	assign a1[0] = ax_s1.x;
	assign a1[1] = ax_s1.y;
	assign a1[2] = ax_s1.z;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			t_n[k]  = OW'(rnd_shr(RW'(omc_s1) * RW'(a1[k]), FRAC));
			sa_n[k] = SAW'(rnd_shr(RW'(s_s1) * RW'(a1[k]), FRAC));
		end
	end

	always_ff @(posedge clk) begin
		if (ld2 && v_s1) begin
			t_s2  <= t_n;
			sa_s2 <= sa_n;
			a_s2  <= a1;
			c_s2  <= c_s1;
		end
	end

	// Stage 3: the nine t_i*a_j terms, row-major.
	logic signed [PW-1:0]  p_n  [9];
	logic signed [PW-1:0]  p_s3 [9];
	logic signed [SAW-1:0] sa_s3 [3];
	logic signed [CW-1:0]  c_s3;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				p_n[3*i+j] = PW'(rnd_shr(RW'(t_s2[i]) * RW'(a_s2[j]), FRAC));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld3 && v_s2) begin
			p_s3  <= p_n;
			sa_s3 <= sa_s2;
			c_s3  <= c_s2;
		end
	end

	// Stage 4: add the cosine or the sine term and saturate.
	rot_mat_t mat_n;

	always_comb begin
		logic signed [SUMW-1:0] c;
		logic signed [SUMW-1:0] sx;
		logic signed [SUMW-1:0] sy;
		logic signed [SUMW-1:0] sz;
		c  = SUMW'(c_s3);
		sx = SUMW'(sa_s3[0]);
		sy = SUMW'(sa_s3[1]);
		sz = SUMW'(sa_s3[2]);
		mat_n.row0_col0 = sat_cw(c + SUMW'(p_s3[0]));
		mat_n.row0_col1 = sat_cw(SUMW'(p_s3[1]) + sz);
		mat_n.row0_col2 = sat_cw(SUMW'(p_s3[2]) - sy);
		mat_n.row1_col0 = sat_cw(SUMW'(p_s3[3]) - sz);
		mat_n.row1_col1 = sat_cw(c + SUMW'(p_s3[4]));
		mat_n.row1_col2 = sat_cw(SUMW'(p_s3[5]) + sx);
		mat_n.row2_col0 = sat_cw(SUMW'(p_s3[6]) + sy);
		mat_n.row2_col1 = sat_cw(SUMW'(p_s3[7]) - sx);
		mat_n.row2_col2 = sat_cw(c + SUMW'(p_s3[8]));
	end

	rot_mat_t mat_s4;

	always_ff @(posedge clk) begin
		if (ld4 && v_s3) begin
			mat_s4 <= mat_n;
		end
	end

	assign mat_valid = v_s4;
	assign mat_item  = mat_s4;

endmodule

/* rtl/aarm_checker.sv */
// ----------------------------------------------------------------------------
// aarm_checker
// Port-level checks for the rotation matrix pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module aarm_checker import aarm_pkg::*; #(
	parameter int STEPS = CORDIC_STEPS_DEF
) (
	input logic     clk,
	input logic     arst_n,
	input logic     axis_valid,
	input logic     axis_ready,
	input logic     mat_valid,
	input logic     mat_ready,
	input rot_mat_t mat_item
);

	localparam int DEPTH = STEPS + 5;
	localparam int CNTW  = $clog2(DEPTH + 2);

	logic [CNTW-1:0] cnt_q;
	logic            in_acc;
	logic            out_acc;

	assign in_acc  = axis_valid && axis_ready;
	assign out_acc = mat_valid && mat_ready;

	// Track items inside the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (in_acc && !out_acc) begin
			cnt_q <= cnt_q + CNTW'(1);
		end else if (out_acc && !in_acc) begin
			cnt_q <= cnt_q - CNTW'(1);
		end
	end

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		mat_valid |-> cnt_q != '0)
		else $error("matrix item without an accepted axis item");

	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNTW'(DEPTH))
		else $error("more items in flight than pipeline stages");

	a_ready_when_empty_out: assert property (@(posedge clk) disable iff (!arst_n)
		!mat_valid |-> axis_ready)
		else $error("input stalled while output register is empty");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		mat_valid && !mat_ready |=> mat_valid && $stable(mat_item))
		else $error("stalled matrix item changed or dropped");

endmodule

bind axis_angle_rotation_matrix aarm_checker #(.STEPS(CORDIC_STEPS)) u_aarm_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.axis_valid (axis_valid),
	.axis_ready (axis_ready),
	.mat_valid  (mat_valid),
	.mat_ready  (mat_ready),
	.mat_item   (mat_item)
);
